// File: sv/bdq_pkg.sv
package bdq_pkg;

    // ring store geometry
    localparam int DEPTH  = 64;
    localparam int DATA_W = 64;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = ADDR_W + 1;

    typedef logic [DATA_W-1:0] t_word;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_count;
    typedef logic [SUM_W-1:0]  t_sum;

    // request codes
    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_REVERSE    = 3'd4
    } t_op;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // store access from the pointer logic
    typedef struct packed {
        logic  we;
        t_addr waddr;
        t_word wdata;
        t_addr raddr_a;
        t_addr raddr_b;
    } t_store_req;

    // ring position one step up
    function automatic t_addr ring_inc(input t_addr pos);
        t_addr res;
        if (pos == t_addr'(DEPTH - 1)) res = '0;
        else res = pos + t_addr'(1);
        return res;
    endfunction

    // ring position one step down
    function automatic t_addr ring_dec(input t_addr pos);
        t_addr res;
        if (pos == '0) res = t_addr'(DEPTH - 1);
        else res = pos - t_addr'(1);
        return res;
    endfunction

    // fold a sum below twice the depth back into the ring
    function automatic t_addr ring_wrap(input t_sum s);
        t_sum res;
        if (s >= t_sum'(DEPTH)) res = s - t_sum'(DEPTH);
        else res = s;
        return t_addr'(res);
    endfunction

endpackage

// File: sv/bdq_store.sv
module bdq_store
    import bdq_pkg::*;
(
    input  logic       i_clk,
    input  t_store_req i_req,
    output t_word      o_rd_a,
    output t_word      o_rd_b
);

    t_word r_mem [DEPTH];
    t_word r_rd_a;
    t_word r_rd_b;
    t_word r_wdata;
    logic  r_fwd_a;
    logic  r_fwd_b;

    // one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rd_a <= r_mem[i_req.raddr_a];
        r_rd_b <= r_mem[i_req.raddr_b];
    end

    // bypass for a read of the slot written in the same cycle
    always_ff @(posedge i_clk) begin
        r_wdata <= i_req.wdata;
        r_fwd_a <= i_req.we && (i_req.waddr == i_req.raddr_a);
        r_fwd_b <= i_req.we && (i_req.waddr == i_req.raddr_b);
    end

    assign o_rd_a = r_fwd_a ? r_wdata : r_rd_a;
    assign o_rd_b = r_fwd_b ? r_wdata : r_rd_b;

endmodule

// File: sv/bdq_core.sv
module bdq_core
    import bdq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_op        i_op,
    input  t_word      i_value,
    input  t_word      i_rd_a,
    input  t_word      i_rd_b,
    output t_store_req o_req,
    output logic       o_valid,
    output t_status    o_status,
    output t_word      o_front_value,
    output t_word      o_back_value,
    output logic       o_is_empty,
    output t_count     o_element_count
);

    // queue state: low end pointer, fill, direction, cached end words
    t_addr   r_head, n_head;
    t_count  r_count, n_count;
    logic    r_rev, n_rev;
    t_word   r_low, n_low;
    t_word   r_high, n_high;
    t_status n_status;

    // result register
    logic    r_valid;
    t_status r_status;
    t_word   r_front;
    t_word   r_back;
    logic    r_empty;
    t_count  r_cnt_out;

    logic is_full;
    logic is_empty;
    logic push_low;
    logic pop_low;
    t_addr end_pos;
    logic n_empty;

    assign is_full  = (r_count == t_count'(DEPTH));
    assign is_empty = (r_count == '0);
    // the logical front sits at the low end unless reversed
    assign push_low = (i_op == OP_PUSH_FRONT) == !r_rev;
    assign pop_low  = (i_op == OP_POP_FRONT) == !r_rev;

    // apply one request to the pointers and end words
    always_comb begin
        n_head      = r_head;
        n_count     = r_count;
        n_rev       = r_rev;
        n_low       = r_low;
        n_high      = r_high;
        n_status    = ST_OK;
        o_req.we    = 1'b0;
        o_req.waddr = ring_wrap(t_sum'(r_head) + t_sum'(r_count));
        o_req.wdata = i_value;
        if (i_valid) begin
            unique case (i_op)
                OP_PUSH_FRONT, OP_PUSH_BACK: begin
                    if (is_full) begin
                        n_status = ST_FULL;
                    end else begin
                        o_req.we = 1'b1;
                        n_count  = r_count + t_count'(1);
                        if (push_low) begin
                            n_head      = ring_dec(r_head);
                            o_req.waddr = n_head;
                            n_low       = i_value;
                            if (is_empty) n_high = i_value;
                        end else begin
                            n_high = i_value;
                            if (is_empty) n_low = i_value;
                        end
                    end
                end
                OP_POP_FRONT, OP_POP_BACK: begin
                    if (is_empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_count = r_count - t_count'(1);
                        if (pop_low) begin
                            n_head = ring_inc(r_head);
                            n_low  = i_rd_a;
                        end else begin
                            n_high = i_rd_b;
                        end
                    end
                end
                OP_REVERSE: begin
                    n_rev = !r_rev;
                end
                default: begin
                    n_status = ST_OK;
                end
            endcase
        end
        // prefetch the inner neighbors of both ends for the next pop
        end_pos       = ring_wrap(t_sum'(n_head) + t_sum'(n_count));
        o_req.raddr_a = ring_inc(n_head);
        o_req.raddr_b = ring_dec(ring_dec(end_pos));
    end

    assign n_empty = (n_count == '0);

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_rev   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
            r_rev   <= n_rev;
            r_valid <= i_valid;
        end
    end

    // cached end words and result payload
    always_ff @(posedge i_clk) begin
        r_low     <= n_low;
        r_high    <= n_high;
        r_status  <= n_status;
        r_empty   <= n_empty;
        r_cnt_out <= n_count;
        if (n_empty) begin
            r_front <= '0;
            r_back  <= '0;
        end else if (n_rev) begin
            r_front <= n_high;
            r_back  <= n_low;
        end else begin
            r_front <= n_low;
            r_back  <= n_high;
        end
    end

    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_front_value   = r_front;
    assign o_back_value    = r_back;
    assign o_is_empty      = r_empty;
    assign o_element_count = r_cnt_out;

endmodule

// File: sv/bounded_deque_with_reverse.sv
// Bounded double-ended queue of 64-bit words with a constant-time reverse.
// Request channel: drive i_opcode and i_push_value with i_start high; the
// request is taken at a rising edge where o_busy is low. Opcodes: push
// front, push back, pop front, pop back, reverse.
// Result channel: o_valid is high for exactly one cycle per request with
// status, element count, empty flag and the front and back words after the
// operation. Results come in request order and cannot be held off.
// Result path: an accepted request passes the input register, then the
// state update into the result register, which drives o_valid and the
// result outputs.
// Throughput: one request per cycle; the ring store has one write port and
// two read ports that prefetch the words next to each end, so any mix of
// pushes and pops runs back to back.
// Reset (synchronous, active low) empties the queue and clears the reverse
// flag; o_busy is high during reset and low afterwards. The store itself
// is not cleared, only occupied slots are ever reported.
// Push on a full queue or pop on an empty one changes nothing and reports
// it in the status.
module bounded_deque_with_reverse
    import bdq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  logic [2:0]        i_opcode,
    input  logic [DATA_W-1:0] i_push_value,
    output logic              o_valid,
    output logic [1:0]        o_status,
    output logic [DATA_W-1:0] o_front_value,
    output logic [DATA_W-1:0] o_back_value,
    output logic              o_is_empty,
    output logic [CNT_W-1:0]  o_element_count
);

    logic       r_busy;
    logic       r_in_valid;
    t_op        r_op;
    t_word      r_value;
    t_store_req req;
    t_word      rd_a;
    t_word      rd_b;
    t_status    status;
    logic       accept;

    assign accept = i_start && !r_busy;
    assign o_busy = r_busy;

    // request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_in_valid <= 1'b0;
        end else begin
            r_busy     <= 1'b0;
            r_in_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= t_op'(i_opcode);
            r_value <= i_push_value;
        end
    end

    // ring store
    bdq_store u_store (
        .i_clk  (i_clk),
        .i_req  (req),
        .o_rd_a (rd_a),
        .o_rd_b (rd_b)
    );

    // pointer logic and result register
    bdq_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (r_in_valid),
        .i_op            (r_op),
        .i_value         (r_value),
        .i_rd_a          (rd_a),
        .i_rd_b          (rd_b),
        .o_req           (req),
        .o_valid         (o_valid),
        .o_status        (status),
        .o_front_value   (o_front_value),
        .o_back_value    (o_back_value),
        .o_is_empty      (o_is_empty),
        .o_element_count (o_element_count)
    );

    assign o_status = status;

endmodule

// File: sv/bdq_checker.sv
module bdq_checker
    import bdq_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_valid,
    input logic [1:0]        o_status,
    input logic [DATA_W-1:0] o_front_value,
    input logic [DATA_W-1:0] o_back_value,
    input logic              o_is_empty,
    input logic [CNT_W-1:0]  o_element_count
);

    // empty flag agrees with the count
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_is_empty == (o_element_count == '0)))
        else $error("empty flag disagrees with element count");

    // an empty queue reports zero words at both ends
    a_empty_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_empty |-> (o_front_value == '0) && (o_back_value == '0))
        else $error("nonzero end word on empty queue");

    // a refused push only happens at full depth
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_FULL) |->
            (o_element_count == CNT_W'(DEPTH)))
        else $error("full status below full depth");

    // a refused pop only happens on an empty queue
    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_EMPTY) |-> o_is_empty)
        else $error("empty status on nonempty queue");

    // count never exceeds the depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_element_count <= CNT_W'(DEPTH)))
        else $error("element count beyond depth");

endmodule

bind bounded_deque_with_reverse bdq_checker u_bdq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .o_status        (o_status),
    .o_front_value   (o_front_value),
    .o_back_value    (o_back_value),
    .o_is_empty      (o_is_empty),
    .o_element_count (o_element_count)
);
